// ----- rtl/pstb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pstb_pkg: shared types and constants
// Sizes, item layouts, codes and the state encoding used by the running
// total table with bisection search.
// ----------------------------------------------------------------------------
package pstb_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned TotalWidth = 32;
  localparam int unsigned AddrWidth  = $clog2(TableDepth);
  localparam int unsigned CountWidth = $clog2(TableDepth + 1);
  localparam int unsigned SlotWidth  = 9;
  localparam int unsigned PosWidth   = 9;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FIND   = 1'b1
  } pstb_op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_ERROR   = 2'd2
  } pstb_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID,
    ST_LAST
  } pstb_state_e;

  typedef struct packed {
    pstb_op_e               op;
    logic [SlotWidth-1:0]   slot_index;
    logic [TotalWidth-1:0]  amount;
  } pstb_in_t;

  typedef struct packed {
    logic [PosWidth-1:0]    position;
    pstb_status_e           status;
  } pstb_out_t;

  // table port request from the sequencer
  typedef struct packed {
    logic                   wr_en;
    logic [AddrWidth-1:0]   wr_addr;
    logic [TotalWidth-1:0]  wr_data;
    logic                   rd_en;
    logic [AddrWidth-1:0]   rd_addr;
  } pstb_mem_req_t;

  typedef struct packed {
    logic                   valid;
    pstb_out_t              data;
  } pstb_res_t;

endpackage
`default_nettype wire

// ----- rtl/pstb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pstb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module pstb_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pstb_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pstb_core: sequencer and shared compare unit
// Handles appends directly from idle and steps the bisection one table read
// per cycle, reusing one magnitude compare and one narrow midpoint adder.
// ----------------------------------------------------------------------------
module pstb_core import pstb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire pstb_in_t              in_i,
  input  wire logic [TotalWidth-1:0] rdata_i,
  output logic                       busy_o,
  output pstb_mem_req_t              mem_req_o,
  output pstb_res_t                  res_o
);

  pstb_state_e state_q, state_d;

  logic [CountWidth-1:0] count_q, count_d;
  logic [TotalWidth-1:0] last_q, last_d;
  logic [TotalWidth-1:0] value_q, value_d;
  logic [CountWidth-1:0] lo_q, lo_d;
  logic [CountWidth-1:0] hi_q, hi_d;
  logic [AddrWidth-1:0]  mid_q, mid_d;

  logic                  accept;
  logic                  find_go;
  logic                  lt, gt, eq;
  logic [CountWidth-1:0] lo_sel, hi_sel;
  logic [CountWidth:0]   span_sum;
  logic                  narrow;
  logic [AddrWidth-1:0]  rd_addr;
  logic [TotalWidth:0]   add_sum;
  logic [TotalWidth-1:0] base;
  logic [TotalWidth-1:0] new_total;
  logic [CountWidth:0]   next_slot;
  pstb_status_e          app_status;

  assign accept  = start && (state_q == ST_IDLE);
  assign find_go = accept && (in_i.op == OP_FIND) && (count_q != '0);
  assign busy_o  = (state_q != ST_IDLE);

  // shared compare against the value being searched
  assign lt = rdata_i < value_q;
  assign gt = rdata_i > value_q;
  assign eq = !lt && !gt;

  // search bounds entering this step
  always_comb begin
    if (state_q == ST_IDLE) begin
      lo_sel = '0;
      hi_sel = count_q;
    end else begin
      lo_sel = lt ? CountWidth'(mid_q) : lo_q;
      hi_sel = gt ? CountWidth'(mid_q) : hi_q;
    end
  end

  assign span_sum = {1'b0, lo_sel} + {1'b0, hi_sel};
  assign narrow   = ({1'b0, lo_sel} + (CountWidth+1)'(1)) < {1'b0, hi_sel};
  // mid stays below hi, so it always fits the address
  assign rd_addr  = narrow ? span_sum[AddrWidth:1] : lo_sel[AddrWidth-1:0];

  // append: saturating running total
  assign base      = (count_q == '0) ? '0 : last_q;
  assign add_sum   = {1'b0, base} + {1'b0, in_i.amount};
  assign new_total = add_sum[TotalWidth] ? '1 : add_sum[TotalWidth-1:0];
  assign next_slot = {1'b0, count_q} + (CountWidth+1)'(1);

  always_comb begin
    if ((CountWidth+1)'(in_i.slot_index) <= {1'b0, count_q}) begin
      app_status = STATUS_IGNORED;
    end else if ((CountWidth+1)'(in_i.slot_index) != next_slot ||
                 count_q >= CountWidth'(TableDepth)) begin
      app_status = STATUS_ERROR;
    end else begin
      app_status = STATUS_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (find_go) begin
          state_d = narrow ? ST_MID : ST_LAST;
        end
      end
      ST_MID: begin
        if (eq) begin
          state_d = ST_IDLE;
        end else begin
          state_d = narrow ? ST_MID : ST_LAST;
        end
      end
      ST_LAST: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    mem_req_o               = '0;
    mem_req_o.rd_addr       = rd_addr;
    mem_req_o.wr_addr       = count_q[AddrWidth-1:0];
    mem_req_o.wr_data       = new_total;
    res_o                   = '0;
    res_o.data.status       = STATUS_OK;
    count_d                 = count_q;
    last_d                  = last_q;
    value_d                 = value_q;
    lo_d                    = lo_q;
    hi_d                    = hi_q;
    mid_d                   = mid_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = in_i.amount;
          if (in_i.op == OP_FIND) begin
            // empty table answers at once with position zero
            res_o.valid = (count_q == '0);
            mem_req_o.rd_en = find_go;
          end else begin
            res_o.valid       = 1'b1;
            res_o.data.status = app_status;
            if (app_status == STATUS_OK) begin
              mem_req_o.wr_en = 1'b1;
              last_d          = new_total;
              count_d         = next_slot[CountWidth-1:0];
            end
          end
        end
      end
      ST_MID: begin
        if (eq) begin
          res_o.valid         = 1'b1;
          res_o.data.position = PosWidth'(mid_q);
        end else begin
          mem_req_o.rd_en = 1'b1;
        end
      end
      ST_LAST: begin
        res_o.valid         = 1'b1;
        res_o.data.position = eq ? PosWidth'(lo_q) : PosWidth'(lo_q + CountWidth'(1));
      end
      default: ;
    endcase
    if (mem_req_o.rd_en) begin
      lo_d  = lo_sel;
      hi_d  = hi_sel;
      mid_d = rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    value_q <= value_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
  end

endmodule
`default_nettype wire

// ----- rtl/prefix_sum_table_bisect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_sum_table_bisect: running total table with bisection search
// Appends saturating running totals to a table and bisects it for a value.
//
//   channel  handshake                     payload
//   item in  start / busy                  in_i  (op, slot_index, amount)
//   result   result_valid_o (one cycle)    res_o (position, status)
//
// An item transfers on a clock edge with start high and busy low. Appends
// and finds on an empty table give their result in the next cycle and do
// not raise busy. A find with n entries holds busy through each
// bisection step (about log2(n), at most 8 for 256 entries), each a
// registered table read, and through the final compare. Its result shows
// in the same cycle that busy drops. Reset empties the table at once;
// there is no clearing pass. Results cannot be stalled: each is shown
// for exactly one cycle.
// ----------------------------------------------------------------------------
module prefix_sum_table_bisect import pstb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire pstb_in_t in_i,
  output logic          result_valid_o,
  output pstb_out_t     res_o
);

  pstb_mem_req_t         mem_req;
  pstb_res_t             res;
  logic [TotalWidth-1:0] rdata;
  logic                  valid_q;
  pstb_out_t             res_q;

  pstb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .in_i      (in_i),
    .rdata_i   (rdata),
    .busy_o    (busy),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  pstb_ram #(
    .Depth (TableDepth),
    .Width (TotalWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.wr_en),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.wr_data),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res.data;
    end
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

  // an append always answers in the next cycle
  a_append_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.op == OP_APPEND |=> result_valid_o)
    else $error("append transfer without result in next cycle");

  // a finished search hands its result out as busy drops
  a_search_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("search ended without a result");

  // no result while a search is still running
  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> !result_valid_o)
    else $error("result strobe during a search");

  a_position_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> res_o.position <= PosWidth'(TableDepth))
    else $error("position beyond table depth");

endmodule
`default_nettype wire

// ----- bench/prefix_sum_table_bisect_tb.sv -----
// ----------------------------------------------------------------------------
// prefix_sum_table_bisect_tb: self-checking bench for the running total table
// Drives append and find commands in random bursts, predicts each result
// from a bench-side copy of the table and checks every result strobe
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module prefix_sum_table_bisect_tb;
  import pstb_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 1050;
  localparam logic [TotalWidth-1:0] TotalMax = '1;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  pstb_in_t  in_i;
  logic      result_valid_o;
  pstb_out_t res_o;

  // bench copy of the table contents
  logic [TotalWidth-1:0] tbl_total [TableDepth];
  int                    tbl_entries;

  pstb_out_t pending_res[$];
  int        err_cnt;
  int        burst_left;
  int        idle_cycles;

  prefix_sum_table_bisect dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [PosWidth-1:0] bisect_position(logic [TotalWidth-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_entries;
    if (tbl_entries == 0) return '0;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_total[mid] < v) lo = mid;
      else if (tbl_total[mid] > v) hi = mid;
      else return PosWidth'(mid);
    end
    if (tbl_total[lo] == v) return PosWidth'(lo);
    return PosWidth'(lo + 1);
  endfunction

  // applies one command to the bench table and returns its result
  function automatic pstb_out_t table_apply(pstb_in_t it);
    pstb_out_t             r;
    logic [TotalWidth-1:0] base;
    logic [TotalWidth:0]   sum;
    int                    slot;
    r.position = '0;
    r.status   = STATUS_OK;
    slot = int'(it.slot_index);
    if (it.op == OP_FIND) begin
      r.position = bisect_position(it.amount);
    end else if (slot <= tbl_entries) begin
      r.status = STATUS_IGNORED;
    end else if (slot != tbl_entries + 1 || tbl_entries >= TableDepth) begin
      r.status = STATUS_ERROR;
    end else begin
      base = (tbl_entries == 0) ? '0 : tbl_total[tbl_entries-1];
      sum  = {1'b0, base} + {1'b0, it.amount};
      tbl_total[tbl_entries] = sum[TotalWidth] ? TotalMax : sum[TotalWidth-1:0];
      tbl_entries++;
    end
    return r;
  endfunction

  // holds start until the transfer, then idles per the burst pattern
  task automatic send_item(input pstb_in_t it);
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_res.insert(pending_res.size(), table_apply(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic append_item(input int slot, input logic [TotalWidth-1:0] amt);
    pstb_in_t it;
    it.op         = OP_APPEND;
    it.slot_index = SlotWidth'(slot);
    it.amount     = amt;
    send_item(it);
  endtask

  task automatic find_item(input logic [TotalWidth-1:0] v);
    pstb_in_t it;
    it.op         = OP_FIND;
    it.slot_index = SlotWidth'($urandom_range(0, 511));
    it.amount     = v;
    send_item(it);
  endtask

  // finds on an empty table and appends that cannot start it
  task automatic test_empty_table();
    find_item('0);
    find_item(TotalMax);
    append_item(0, 32'd5);
    append_item(2, 32'd5);
    append_item(511, TotalMax);
  endtask

  // a few entries with a repeated total, then every kind of probe
  task automatic test_first_entries();
    append_item(1, 32'd0);
    append_item(2, 32'd7);
    append_item(3, 32'd0);
    append_item(4, 32'd100);
    append_item(3, 32'd9);
    append_item(0, 32'd9);
    append_item(9, 32'd9);
    find_item(32'd0);
    find_item(32'd7);
    find_item(32'd6);
    find_item(32'd8);
    find_item(32'd107);
    find_item(32'd200);
    find_item(TotalMax);
  endtask

  task automatic test_random_traffic(input int n);
    int                    kind;
    int                    idx;
    logic [TotalWidth-1:0] v;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 24 && tbl_entries < 240) begin
        v = ($urandom_range(0, 4) == 0) ? '0 : TotalWidth'($urandom_range(1, 1 << 20));
        append_item(tbl_entries + 1, v);
      end else if (kind < 32) begin
        append_item($urandom_range(0, tbl_entries), $urandom());
      end else if (kind < 38) begin
        append_item($urandom_range(tbl_entries + 2, 511), $urandom());
      end else if (kind < 42) begin
        append_item($urandom_range(0, 511), $urandom());
      end else begin
        kind = $urandom_range(0, 9);
        idx  = (tbl_entries == 0) ? 0 : $urandom_range(0, tbl_entries - 1);
        if (tbl_entries == 0 || kind >= 8) v = $urandom();
        else if (kind < 4) v = tbl_total[idx];
        else if (kind == 4) v = tbl_total[idx] + 1'b1;
        else if (kind == 5) v = tbl_total[idx] - 1'b1;
        else if (kind == 6) v = '0;
        else v = TotalMax;
        find_item(v);
      end
    end
  endtask

  // totals clamp at all ones, then the table is filled and overfilled
  task automatic test_saturation_and_full();
    append_item(tbl_entries + 1, 32'hF000_0000);
    find_item(tbl_total[tbl_entries-1]);
    append_item(tbl_entries + 1, 32'h2000_0000);
    append_item(tbl_entries + 1, 32'd0);
    append_item(tbl_entries + 1, TotalMax);
    find_item(TotalMax);
    find_item(TotalMax - 1'b1);
    while (tbl_entries < TableDepth) append_item(tbl_entries + 1, $urandom());
    append_item(TableDepth + 1, 32'd1);
    append_item(TableDepth, 32'd1);
    append_item(TableDepth + 2, 32'd1);
    append_item(511, 32'd1);
    find_item('0);
    find_item(TotalMax);
    find_item(tbl_total[TableDepth/2]);
    find_item(tbl_total[TableDepth/2] + 1'b1);
  endtask

  always @(posedge clk_i) begin
    pstb_out_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result position %0d status %0d",
                 $time, res_o.position, res_o.status);
      end else begin
        exp_res = pending_res.pop_front();
        if (res_o.position !== exp_res.position) begin
          err_cnt++;
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, exp_res.position, res_o.position);
        end
        if (res_o.status !== exp_res.status) begin
          err_cnt++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_res.status, res_o.status);
        end
      end
    end
  end

  // watchdog: ends the run after too long without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_res.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    err_cnt     = 0;
    idle_cycles = 0;
    burst_left  = 0;
    tbl_entries = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    in_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_first_entries();
    test_random_traffic(RandomItems);
    test_saturation_and_full();

    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pstb_pkg.sv
rtl/pstb_ram.sv
rtl/pstb_core.sv
rtl/prefix_sum_table_bisect.sv
bench/prefix_sum_table_bisect_tb.sv
